// File: sv/bts_pkg.sv
package bts_pkg;

  typedef enum logic [1:0] {
    CMD_WRITE_KEY   = 2'd0,
    CMD_WRITE_PTR   = 2'd1,
    CMD_WRITE_COUNT = 2'd2,
    CMD_SEARCH      = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_COUNT_RD,
    ST_COUNT_WAIT,
    ST_BSEARCH,
    ST_KEY_WAIT,
    ST_LAST_WAIT,
    ST_PTR_WAIT,
    ST_DONE
  } state_t;

  localparam logic REG_INDEX_START = 1'b0;
  localparam logic REG_INDEX_END   = 1'b1;

  localparam int OFFSET_W = 31;
  localparam int KEY_W    = 64;
  localparam int PTR_W    = 32;
  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 32;

  localparam logic [PTR_W-1:0] LEAF_NONE = '1;

endpackage

// File: sv/bts_div.sv
module bts_div import bts_pkg::*; #(
  parameter int NODE_BYTES = 4096,
  parameter int QW = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [OFFSET_W-1:0] dividend,
  output logic                busy,
  output logic [QW-1:0]       quotient
);

  localparam int SHIFT = OFFSET_W + $clog2(NODE_BYTES);
  localparam int MW = OFFSET_W + 1;
  localparam int PW = OFFSET_W + MW;
  localparam longint RECIP = ((longint'(1) << SHIFT) + longint'(NODE_BYTES) - 1)
                             / longint'(NODE_BYTES);
  localparam logic [MW-1:0] MULT = MW'(RECIP);

  logic                pending;
  logic [OFFSET_W-1:0] num;
  logic [PW-1:0]       prod;

  assign busy     = pending;
  assign quotient = prod[SHIFT +: QW];

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= 1'b0;
    end else begin
      pending <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num <= dividend;
    end
    if (pending) begin
      prod <= PW'(num) * PW'(MULT);
    end
  end

endmodule

// File: sv/bts_store.sv
module bts_store import bts_pkg::*; #(
  parameter int NW = 8,
  parameter int SW = 8
) (
  input  logic                clk,
  input  logic                key_we,
  input  logic [NW+SW-1:0]    key_waddr,
  input  logic [KEY_W-1:0]    key_wdata,
  input  logic [NW+SW-1:0]    key_raddr,
  output logic [KEY_W-1:0]    key_rdata,
  input  logic                ptr_we,
  input  logic [NW+SW-1:0]    ptr_waddr,
  input  logic [PTR_W-1:0]    ptr_wdata,
  input  logic [NW+SW-1:0]    ptr_raddr,
  output logic [PTR_W-1:0]    ptr_rdata
);

  localparam int DEPTH = 1 << (NW + SW);

  logic [KEY_W-1:0] key_mem [DEPTH];
  logic [PTR_W-1:0] ptr_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    key_rdata <= key_mem[key_raddr];
  end

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      ptr_mem[ptr_waddr] <= ptr_wdata;
    end
    ptr_rdata <= ptr_mem[ptr_raddr];
  end

endmodule

// File: sv/btree_index_search_top.sv
// Search unit over the node store of a static B-tree index.
// Input stream s_axis: tuser holds the command, tdata the node, slot, key and
// entry value. Write commands (key, pointer, key count) update the node store in
// the cycle they are accepted, give no result, and the next item may follow in
// the next cycle. A search command walks from the root node at index_start down
// to a leaf and gives one result on m_axis: the leaf offset in tdata and an error
// flag in tuser (pointer past the end of the node store or level limit reached).
// Key counts share the key memory at the slot just past the last key.
// Per level, the offset is mapped to a node by a constant reciprocal multiply,
// the key count of the node is read, and a binary search over its keys picks
// the child pointer; each binary search probe is one registered read of the key
// memory, and an empty node goes straight to its pointer in slot 0. A search is
// accepted, checked at each level and ends with an output load. One item is in
// work at a
// time; a finished result waits in the output register while the next item is
// accepted, and a further search holds its result until m_axis takes the first.
// Reset clears the control state and both offset registers; the node store holds no
// defined contents until written, and no clearing pass is needed. The configuration
// channel is always ready; the user must write it only while idle (not enforced).
module btree_index_search_top import bts_pkg::*; #(
  parameter int MAX_KEYS = 255,
  parameter int NODE_COUNT = 256,
  parameter int NODE_BYTES = 4096,
  parameter int MAX_LEVELS = 8
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,  // node_index, slot, search_key, entry_value
  input  logic [1:0]            s_axis_tuser,  // command
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0] m_axis_tdata,  // leaf_offset
  output logic                  m_axis_tuser,  // status
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic                  cfg_addr,
  input  logic [OFFSET_W-1:0]   cfg_data
);

  localparam int QW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int NW = (QW > 8) ? 8 : QW;
  localparam int SW = $clog2(MAX_KEYS + 1);
  localparam int LW = $clog2(MAX_LEVELS + 1);
  localparam logic [32:0] LIMIT = 33'(longint'(NODE_COUNT) * longint'(NODE_BYTES));
  localparam logic [SW-1:0] COUNT_SLOT = SW'(MAX_KEYS);

  state_t state, state_next;

  logic [OFFSET_W-1:0] index_start;
  logic [OFFSET_W-1:0] index_end;

  logic [PTR_W-1:0] off, off_next;
  logic [LW-1:0]    level, level_next;
  logic [KEY_W-1:0] skey, skey_next;
  logic [NW-1:0]    node, node_next;
  logic [SW-1:0]    cnt, cnt_next;
  logic [SW-1:0]    lo, lo_next;
  logic [SW-1:0]    hi, hi_next;
  logic [SW-1:0]    mid, mid_next;
  logic [PTR_W-1:0] res_leaf, res_leaf_next;
  logic             res_status, res_status_next;

  logic                  out_valid;
  logic [OUT_DATA_W-1:0] out_data;
  logic                  out_user;
  logic                  out_load;

  cmd_t             in_cmd;
  logic [7:0]       in_node;
  logic [7:0]       in_slot;
  logic [KEY_W-1:0] in_key;
  logic [PTR_W-1:0] in_value;
  logic             in_acc;
  logic             node_ok;
  logic [SW-1:0]    sat_count;

  logic               key_we;
  logic [NW+SW-1:0]   key_waddr;
  logic [KEY_W-1:0]   key_wdata;
  logic [NW+SW-1:0]   key_raddr;
  logic [KEY_W-1:0]   key_rdata;
  logic               ptr_we;
  logic [NW+SW-1:0]   ptr_waddr;
  logic [NW+SW-1:0]   ptr_raddr;
  logic [PTR_W-1:0]   ptr_rdata;

  logic                div_start;
  logic                div_busy;
  logic [QW-1:0]       div_q;
  logic [OFFSET_W-1:0] diff;
  logic                key_less;
  logic [SW:0]         mid_sum;

  assign in_cmd   = cmd_t'(s_axis_tuser);
  assign in_node  = s_axis_tdata[7:0];
  assign in_slot  = s_axis_tdata[15:8];
  assign in_key   = s_axis_tdata[79:16];
  assign in_value = s_axis_tdata[111:80];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready     = 1'b1;

  assign node_ok   = (32'(in_node) < 32'(NODE_COUNT));
  assign sat_count = (in_value > 32'(MAX_KEYS)) ? COUNT_SLOT : SW'(in_value);

  always_comb begin
    key_we    = 1'b0;
    key_waddr = {NW'(in_node), SW'(in_slot)};
    key_wdata = in_key;
    ptr_we    = 1'b0;
    ptr_waddr = {NW'(in_node), SW'(in_slot)};
    if (in_acc && node_ok) begin
      case (in_cmd)
        CMD_WRITE_KEY: begin
          key_we = (32'(in_slot) < 32'(MAX_KEYS));
        end
        CMD_WRITE_PTR: begin
          ptr_we = (32'(in_slot) <= 32'(MAX_KEYS));
        end
        CMD_WRITE_COUNT: begin
          key_we    = 1'b1;
          key_waddr = {NW'(in_node), COUNT_SLOT};
          key_wdata = KEY_W'(sat_count);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_start <= '0;
      index_end   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_addr)
        REG_INDEX_START: index_start <= cfg_data;
        REG_INDEX_END:   index_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  bts_store #(
    .NW(NW),
    .SW(SW)
  ) u_store (
    .clk       (clk),
    .key_we    (key_we),
    .key_waddr (key_waddr),
    .key_wdata (key_wdata),
    .key_raddr (key_raddr),
    .key_rdata (key_rdata),
    .ptr_we    (ptr_we),
    .ptr_waddr (ptr_waddr),
    .ptr_wdata (in_value),
    .ptr_raddr (ptr_raddr),
    .ptr_rdata (ptr_rdata)
  );

  bts_div #(
    .NODE_BYTES(NODE_BYTES),
    .QW(QW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (diff),
    .busy     (div_busy),
    .quotient (div_q)
  );

  assign diff     = off[OFFSET_W-1:0] - index_start;
  assign key_less = ($signed(key_rdata) < $signed(skey));
  assign mid_sum  = {1'b0, lo} + {1'b0, hi};
  assign out_load = (state == ST_DONE) && (!out_valid || m_axis_tready);

  always_comb begin
    state_next      = state;
    off_next        = off;
    level_next      = level;
    skey_next       = skey;
    node_next       = node;
    cnt_next        = cnt;
    lo_next         = lo;
    hi_next         = hi;
    mid_next        = mid;
    res_leaf_next   = res_leaf;
    res_status_next = res_status;
    div_start       = 1'b0;
    key_raddr       = {node, COUNT_SLOT};
    ptr_raddr       = {node, lo};
    case (state)
      ST_IDLE: begin
        if (in_acc && in_cmd == CMD_SEARCH) begin
          skey_next  = in_key;
          off_next   = {1'b0, index_start};
          level_next = '0;
          if (index_end == index_start) begin
            res_leaf_next   = '0;
            res_status_next = 1'b0;
            state_next      = ST_DONE;
          end else begin
            state_next = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if (off[PTR_W-1] || off[OFFSET_W-1:0] < index_start) begin
          res_leaf_next   = off;
          res_status_next = 1'b0;
          state_next      = ST_DONE;
        end else if (level >= LW'(MAX_LEVELS) || {2'b00, diff} >= LIMIT) begin
          res_leaf_next   = LEAF_NONE;
          res_status_next = 1'b1;
          state_next      = ST_DONE;
        end else begin
          div_start  = 1'b1;
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!div_busy) begin
          node_next  = NW'(div_q);
          state_next = ST_COUNT_RD;
        end
      end
      ST_COUNT_RD: begin
        key_raddr  = {node, COUNT_SLOT};
        state_next = ST_COUNT_WAIT;
      end
      ST_COUNT_WAIT: begin
        cnt_next = key_rdata[SW-1:0];
        lo_next  = '0;
        if (key_rdata[SW-1:0] == '0) begin
          ptr_raddr  = {node, {SW{1'b0}}};
          state_next = ST_PTR_WAIT;
        end else begin
          hi_next    = key_rdata[SW-1:0] - 1'b1;
          state_next = ST_BSEARCH;
        end
      end
      ST_BSEARCH: begin
        if (lo < hi) begin
          mid_next   = mid_sum[SW:1];
          key_raddr  = {node, mid_sum[SW:1]};
          state_next = ST_KEY_WAIT;
        end else begin
          key_raddr  = {node, lo};
          state_next = ST_LAST_WAIT;
        end
      end
      ST_KEY_WAIT: begin
        if (key_less) begin
          lo_next = mid + 1'b1;
        end else begin
          hi_next = mid;
        end
        state_next = ST_BSEARCH;
      end
      ST_LAST_WAIT: begin
        ptr_raddr  = {node, key_less ? cnt : lo};
        state_next = ST_PTR_WAIT;
      end
      ST_PTR_WAIT: begin
        off_next   = ptr_rdata;
        level_next = level + 1'b1;
        state_next = ST_CHECK;
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    off        <= off_next;
    level      <= level_next;
    skey       <= skey_next;
    node       <= node_next;
    cnt        <= cnt_next;
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    res_leaf   <= res_leaf_next;
    res_status <= res_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data <= res_leaf;
      out_user <= res_status;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_data;
  assign m_axis_tuser  = out_user;

endmodule
